### rtl/frame_deframer_crc16_check_macros.svh
// assertion macros shared by the deframer rtl
`ifndef FRAME_DEFRAMER_CRC16_CHECK_MACROS_SVH
`define FRAME_DEFRAMER_CRC16_CHECK_MACROS_SVH

// same-cycle implication, checked outside reset
`define FDC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// next-cycle implication, checked outside reset
`define FDC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

### rtl/fdcrc_pkg.sv
// package: constants, types and crc helper for the frame deframer
`default_nettype none

package fdcrc_pkg;

    localparam int unsigned HEADER_BYTES = 7;
    localparam int unsigned MAX_PAYLOAD  = 256;
    localparam int unsigned HCNT_W       = $clog2(HEADER_BYTES);
    localparam int unsigned PLEN_W       = 9;

    localparam logic [7:0]  SYNC_A     = 8'h54;
    localparam logic [7:0]  SYNC_B     = 8'h4D;
    localparam logic [7:0]  DIR_DEVICE = 8'h01;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [7:0]  VER_RESET  = 8'h02;
    localparam logic [PLEN_W-1:0] MAXLEN_RESET = PLEN_W'(MAX_PAYLOAD);
    localparam logic [PLEN_W-1:0] PLEN_SAT     = {PLEN_W{1'b1}};
    localparam logic [HCNT_W-1:0] HCNT_LAST    = HCNT_W'(HEADER_BYTES - 1);

    // header byte positions
    localparam int unsigned HB_VER   = 0;
    localparam int unsigned HB_FLAGS = 1;
    localparam int unsigned HB_LEN_L = 2;
    localparam int unsigned HB_LEN_H = 3;
    localparam int unsigned HB_CMD_L = 4;
    localparam int unsigned HB_CMD_H = 5;
    localparam int unsigned HB_SEQ   = 6;

    // configuration register indexes
    localparam logic REG_EXP_VERSION = 1'b0;
    localparam logic REG_MAX_LENGTH  = 1'b1;

    typedef enum logic [4:0] {
        PH_HUNT    = 5'b00001,
        PH_SECOND  = 5'b00010,
        PH_HEADER  = 5'b00100,
        PH_PAYLOAD = 5'b01000,
        PH_TRAILER = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PAYLOAD  = 3'd1,
        EV_GOOD     = 3'd2,
        EV_CRC_FAIL = 3'd3,
        EV_WRONG_DIR = 3'd4,
        EV_HDR_REJ  = 3'd5
    } t_event;

    // crc-16 msb first, one byte
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/frame_deframer_crc16_check.sv
// Byte-stream frame deframer with sync hunt, header checks and CRC-16 verification.
//
// Input: one received byte per slave transaction (tdata[7:0]). Output: exactly one result
// per input byte on the master side; tuser carries the event code, tdata the payload byte,
// its index, header fields, the latched length and both frame counters.
// Configuration: plain write port, index 0 expected version, index 1 maximum payload length;
// write only while no byte is in flight.
// Timing: a byte's result is registered and appears in the cycle after its transaction.
// Throughput: one byte per cycle while results drain; the byte-wide crc update and the
// phase logic sit between the parser state and the output register.
// Reset (synchronous, active low): parser returns to the sync hunt, counters clear,
// expected version 2, maximum length 256, output register empty.
// Stall: the output register holds its result while the master side is not ready; a new byte
// is still taken in the same cycle that the waiting result leaves, so the slave side only
// stalls while the result register is full and not being drained.
`default_nettype none

module frame_deframer_crc16_check (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [7:0]   i_s_axis_tdata,   // [7:0] rx_byte
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // [7:0] data_byte, [15:8] payload_index, [31:16] frame_cmd, [39:32] frame_flags,
    // [47:40] frame_seq, [56:48] payload_length, [88:57] good_frames,
    // [120:89] crc_failures, [127:121] zero
    output logic [127:0]      o_m_axis_tdata,
    output logic [2:0]        o_m_axis_tuser,   // [2:0] event_res
    input  wire logic         i_cfg_wr_en,
    input  wire logic         i_cfg_index,
    input  wire logic [8:0]   i_cfg_data
);

    localparam int unsigned PW = fdcrc_pkg::PLEN_W;
    localparam int unsigned HW = fdcrc_pkg::HCNT_W;

    logic [7:0]    r_exp_ver;
    logic [PW-1:0] r_max_len;

    fdcrc_pkg::t_phase r_phase, n_phase;
    logic [7:0]    r_hdr [fdcrc_pkg::HEADER_BYTES];
    logic [HW-1:0] r_hdr_cnt, n_hdr_cnt;
    logic [PW-1:0] r_pay_cnt, n_pay_cnt;
    logic [PW-1:0] r_len, n_len;
    logic [15:0]   r_crc, n_crc;
    logic [7:0]    r_tr_low, n_tr_low;
    logic          r_tr_cnt, n_tr_cnt;
    logic [31:0]   r_good, n_good;
    logic [31:0]   r_fail, n_fail;

    logic          r_out_valid;
    logic [127:0]  r_out_data;
    logic [2:0]    r_out_ev;

    fdcrc_pkg::t_event n_ev;
    logic [7:0]    n_data;
    logic [7:0]    n_idx;
    logic          n_show;
    logic [PW-1:0] n_plen;
    logic [7:0]    w_seq;
    logic [15:0]   w_cmd;

    logic          w_in_acc;
    logic [7:0]    w_b;
    logic [15:0]   w_hlen;
    logic [PW-1:0] w_lim;
    logic [15:0]   w_crc_upd;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_b             = i_s_axis_tdata;
    assign w_hlen          = {r_hdr[fdcrc_pkg::HB_LEN_H], r_hdr[fdcrc_pkg::HB_LEN_L]};
    assign w_lim           = (r_max_len > PW'(fdcrc_pkg::MAX_PAYLOAD)) ?
                             PW'(fdcrc_pkg::MAX_PAYLOAD) : r_max_len;
    assign w_crc_upd       = fdcrc_pkg::crc_feed(r_crc, w_b);
    assign w_cmd           = {r_hdr[fdcrc_pkg::HB_CMD_H], r_hdr[fdcrc_pkg::HB_CMD_L]};
    // on a rejected header the sequence byte is the one arriving now
    assign w_seq           = (n_ev == fdcrc_pkg::EV_HDR_REJ) ? w_b : r_hdr[fdcrc_pkg::HB_SEQ];

    always_comb begin
        n_phase   = r_phase;
        n_hdr_cnt = r_hdr_cnt;
        n_pay_cnt = r_pay_cnt;
        n_len     = r_len;
        n_crc     = r_crc;
        n_tr_low  = r_tr_low;
        n_tr_cnt  = r_tr_cnt;
        n_good    = r_good;
        n_fail    = r_fail;
        n_ev      = fdcrc_pkg::EV_NONE;
        n_data    = 8'h00;
        n_idx     = 8'h00;
        n_show    = 1'b0;
        n_plen    = '0;
        case (r_phase)
            fdcrc_pkg::PH_HUNT: begin
                if (w_b == fdcrc_pkg::SYNC_A) begin
                    n_phase = fdcrc_pkg::PH_SECOND;
                end
            end
            fdcrc_pkg::PH_SECOND: begin
                if (w_b == fdcrc_pkg::SYNC_B) begin
                    n_phase   = fdcrc_pkg::PH_HEADER;
                    n_hdr_cnt = '0;
                    n_crc     = fdcrc_pkg::CRC_INIT;
                end else if (w_b != fdcrc_pkg::SYNC_A) begin
                    n_phase = fdcrc_pkg::PH_HUNT;
                end
            end
            fdcrc_pkg::PH_HEADER: begin
                n_crc = w_crc_upd;
                if (r_hdr_cnt == fdcrc_pkg::HCNT_LAST) begin
                    if (r_hdr[fdcrc_pkg::HB_VER] != r_exp_ver ||
                        w_hlen > 16'(w_lim)) begin
                        n_ev      = fdcrc_pkg::EV_HDR_REJ;
                        n_show    = 1'b1;
                        n_plen    = (w_hlen > 16'(fdcrc_pkg::PLEN_SAT)) ?
                                    fdcrc_pkg::PLEN_SAT : w_hlen[PW-1:0];
                        n_phase   = fdcrc_pkg::PH_HUNT;
                        n_hdr_cnt = '0;
                        n_pay_cnt = '0;
                        n_tr_cnt  = 1'b0;
                    end else begin
                        n_len     = w_hlen[PW-1:0];
                        n_pay_cnt = '0;
                        n_tr_cnt  = 1'b0;
                        n_hdr_cnt = '0;
                        n_phase   = (w_hlen == 16'h0000) ? fdcrc_pkg::PH_TRAILER :
                                                          fdcrc_pkg::PH_PAYLOAD;
                    end
                end else begin
                    n_hdr_cnt = r_hdr_cnt + HW'(1);
                end
            end
            fdcrc_pkg::PH_PAYLOAD: begin
                n_ev      = fdcrc_pkg::EV_PAYLOAD;
                n_data    = w_b;
                n_idx     = r_pay_cnt[7:0];
                n_show    = 1'b1;
                n_plen    = r_len;
                n_crc     = w_crc_upd;
                n_pay_cnt = r_pay_cnt + PW'(1);
                if (n_pay_cnt >= r_len) begin
                    n_phase  = fdcrc_pkg::PH_TRAILER;
                    n_tr_cnt = 1'b0;
                end
            end
            fdcrc_pkg::PH_TRAILER: begin
                if (!r_tr_cnt) begin
                    n_tr_low = w_b;
                    n_tr_cnt = 1'b1;
                end else begin
                    n_show = 1'b1;
                    n_plen = r_len;
                    if ({w_b, r_tr_low} == r_crc) begin
                        if ((r_hdr[fdcrc_pkg::HB_FLAGS] & fdcrc_pkg::DIR_DEVICE) != 8'h00) begin
                            n_ev   = fdcrc_pkg::EV_GOOD;
                            n_good = r_good + 32'd1;
                        end else begin
                            n_ev = fdcrc_pkg::EV_WRONG_DIR;
                        end
                    end else begin
                        n_ev   = fdcrc_pkg::EV_CRC_FAIL;
                        n_fail = r_fail + 32'd1;
                    end
                    n_phase   = fdcrc_pkg::PH_HUNT;
                    n_hdr_cnt = '0;
                    n_pay_cnt = '0;
                    n_tr_cnt  = 1'b0;
                end
            end
            default: begin
                n_phase   = fdcrc_pkg::PH_HUNT;
                n_hdr_cnt = '0;
                n_pay_cnt = '0;
                n_tr_cnt  = 1'b0;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_ver <= fdcrc_pkg::VER_RESET;
            r_max_len <= fdcrc_pkg::MAXLEN_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                fdcrc_pkg::REG_EXP_VERSION: r_exp_ver <= i_cfg_data[7:0];
                fdcrc_pkg::REG_MAX_LENGTH:  r_max_len <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= fdcrc_pkg::PH_HUNT;
            r_hdr_cnt <= '0;
            r_pay_cnt <= '0;
            r_len     <= '0;
            r_crc     <= fdcrc_pkg::CRC_INIT;
            r_tr_cnt  <= 1'b0;
            r_good    <= '0;
            r_fail    <= '0;
        end else if (w_in_acc) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_pay_cnt <= n_pay_cnt;
            r_len     <= n_len;
            r_crc     <= n_crc;
            r_tr_cnt  <= n_tr_cnt;
            r_good    <= n_good;
            r_fail    <= n_fail;
        end
    end

    // header bytes and trailer low byte, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_tr_low <= n_tr_low;
            if (r_phase == fdcrc_pkg::PH_HEADER) begin
                r_hdr[r_hdr_cnt] <= w_b;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_ev   <= n_ev;
            r_out_data <= {7'd0, n_fail, n_good, n_plen,
                           n_show ? w_seq : 8'h00,
                           n_show ? r_hdr[fdcrc_pkg::HB_FLAGS] : 8'h00,
                           n_show ? w_cmd : 16'h0000,
                           n_idx, n_data};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_ev;

`include "frame_deframer_crc16_check_macros.svh"

    `FDC_ASSERT_NOW(a_pay_below_len, r_phase == fdcrc_pkg::PH_PAYLOAD, r_pay_cnt < r_len)
    `FDC_ASSERT_NOW(a_len_in_limit, r_phase == fdcrc_pkg::PH_PAYLOAD, r_len <= PW'(fdcrc_pkg::MAX_PAYLOAD))
    `FDC_ASSERT_NEXT(a_good_step, w_in_acc && n_ev == fdcrc_pkg::EV_GOOD, r_good == 32'($past(r_good) + 32'd1))
    `FDC_ASSERT_NEXT(a_fail_hold, w_in_acc && n_ev != fdcrc_pkg::EV_CRC_FAIL, $stable(r_fail))
    `FDC_ASSERT_NEXT(a_verdict_to_hunt, w_in_acc && n_ev != fdcrc_pkg::EV_NONE && n_ev != fdcrc_pkg::EV_PAYLOAD, r_phase == fdcrc_pkg::PH_HUNT)

endmodule

`default_nettype wire

### sim/testbench.sv
// testbench for the frame deframer: frame stimulus, byte-level predictor and result checks
module testbench;

    localparam logic [7:0]  SYNC_FIRST     = 8'h54;
    localparam logic [7:0]  SYNC_SECOND    = 8'h4D;
    localparam logic [7:0]  DEVICE_DIR_BIT = 8'h01;
    localparam logic [15:0] CRC16_POLY     = 16'h1021;
    localparam logic [15:0] CRC16_SEED     = 16'hFFFF;
    localparam int          HDR_BYTES      = 7;
    localparam int          PAYLOAD_CAP    = 256;
    localparam int          CYCLE_LIMIT    = 500000;
    localparam int          LONG_HOLD      = 150;
    localparam int          RUN_BYTES      = 220;

    typedef struct packed {
        fdcrc_pkg::t_event ev;
        logic [7:0]  data;
        logic [7:0]  idx;
        logic [15:0] cmd;
        logic [7:0]  flags;
        logic [7:0]  seq;
        logic [8:0]  plen;
        logic [31:0] good;
        logic [31:0] fails;
    } t_frame_result;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         rx_valid  = 1'b0;
    logic         rx_ready;
    logic [7:0]   rx_data   = 8'h00;
    logic         ev_valid;
    logic         ev_ready  = 1'b0;
    logic [127:0] ev_data;
    logic [2:0]   ev_user;
    logic         cfg_we    = 1'b0;
    logic         cfg_idx   = fdcrc_pkg::REG_EXP_VERSION;
    logic [8:0]   cfg_wdata = 9'h000;

    // predictor state
    fdcrc_pkg::t_phase dm_phase = fdcrc_pkg::PH_HUNT;
    logic [7:0]  dm_hdr [HDR_BYTES];
    int          dm_hdr_cnt = 0;
    logic [8:0]  dm_pay_cnt = 9'd0;
    logic [8:0]  dm_len     = 9'd0;
    logic [15:0] dm_crc     = CRC16_SEED;
    logic [7:0]  dm_trl_low = 8'h00;
    bit          dm_trl_seen = 1'b0;
    logic [31:0] dm_good    = 32'd0;
    logic [31:0] dm_fails   = 32'd0;
    logic [7:0]  dm_ver     = 8'h02;
    logic [8:0]  dm_max     = 9'd256;

    t_frame_result results_due [$];
    t_frame_result due_now;
    logic [7:0]    rx_backlog [$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    int  bytes_made = 0;
    bit  rx_taken = 1'b0;
    int  tx_gap = 0;
    int  tx_pick;
    int  hold_left = 0;
    int  sink_pick;
    int  holds_asked = 0;
    int  holds_served = 0;
    bit  sender_gaps = 1'b0;
    bit  sink_stalls = 1'b0;
    logic [7:0] gen_ver = 8'h02;
    logic [8:0] gen_max = 9'd256;

    frame_deframer_crc16_check uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (rx_valid),
        .o_s_axis_tready (rx_ready),
        .i_s_axis_tdata  (rx_data),
        .o_m_axis_tvalid (ev_valid),
        .i_m_axis_tready (ev_ready),
        .o_m_axis_tdata  (ev_data),
        .o_m_axis_tuser  (ev_user),
        .i_cfg_wr_en     (cfg_we),
        .i_cfg_index     (cfg_idx),
        .i_cfg_data      (cfg_wdata)
    );

    always #6 clk = ~clk;

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     results_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // bitwise crc-16, msb first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c = {c[14:0], 1'b0} ^ (fb ? CRC16_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void dm_to_hunt();
        dm_phase = fdcrc_pkg::PH_HUNT;
        dm_hdr_cnt = 0;
        dm_pay_cnt = 9'd0;
        dm_trl_seen = 1'b0;
    endfunction

    function automatic t_frame_result deframe_byte(input logic [7:0] b);
        t_frame_result r;
        logic [15:0]   len16;
        logic [15:0]   rx_crc;
        int            cap;
        bit            show;
        r = '0;
        r.ev = fdcrc_pkg::EV_NONE;
        show = 1'b0;
        case (dm_phase)
            fdcrc_pkg::PH_HUNT: begin
                if (b == SYNC_FIRST) dm_phase = fdcrc_pkg::PH_SECOND;
            end
            fdcrc_pkg::PH_SECOND: begin
                if (b == SYNC_SECOND) begin
                    dm_phase = fdcrc_pkg::PH_HEADER;
                    dm_hdr_cnt = 0;
                    dm_crc = CRC16_SEED;
                end else if (b != SYNC_FIRST) begin
                    dm_phase = fdcrc_pkg::PH_HUNT;
                end
            end
            fdcrc_pkg::PH_HEADER: begin
                dm_hdr[dm_hdr_cnt] = b;
                dm_hdr_cnt++;
                dm_crc = crc16_step(dm_crc, b);
                if (dm_hdr_cnt >= HDR_BYTES) begin
                    len16 = {dm_hdr[3], dm_hdr[2]};
                    cap = (dm_max > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(dm_max);
                    if (dm_hdr[0] != dm_ver || int'(len16) > cap) begin
                        r.ev = fdcrc_pkg::EV_HDR_REJ;
                        show = 1'b1;
                        r.plen = (len16 > 16'h01FF) ? 9'h1FF : len16[8:0];
                        dm_to_hunt();
                    end else begin
                        dm_len = len16[8:0];
                        dm_pay_cnt = 9'd0;
                        dm_trl_seen = 1'b0;
                        dm_phase = (len16 == 16'd0) ? fdcrc_pkg::PH_TRAILER :
                                                      fdcrc_pkg::PH_PAYLOAD;
                    end
                end
            end
            fdcrc_pkg::PH_PAYLOAD: begin
                r.ev = fdcrc_pkg::EV_PAYLOAD;
                r.data = b;
                r.idx = dm_pay_cnt[7:0];
                r.plen = dm_len;
                show = 1'b1;
                dm_crc = crc16_step(dm_crc, b);
                dm_pay_cnt = dm_pay_cnt + 9'd1;
                if (dm_pay_cnt >= dm_len) begin
                    dm_phase = fdcrc_pkg::PH_TRAILER;
                    dm_trl_seen = 1'b0;
                end
            end
            fdcrc_pkg::PH_TRAILER: begin
                if (!dm_trl_seen) begin
                    dm_trl_low = b;
                    dm_trl_seen = 1'b1;
                end else begin
                    rx_crc = {b, dm_trl_low};
                    show = 1'b1;
                    r.plen = dm_len;
                    if (rx_crc != dm_crc) begin
                        r.ev = fdcrc_pkg::EV_CRC_FAIL;
                        dm_fails = dm_fails + 32'd1;
                    end else if ((dm_hdr[1] & DEVICE_DIR_BIT) != 8'h00) begin
                        r.ev = fdcrc_pkg::EV_GOOD;
                        dm_good = dm_good + 32'd1;
                    end else begin
                        r.ev = fdcrc_pkg::EV_WRONG_DIR;
                    end
                    dm_to_hunt();
                end
            end
            default: dm_to_hunt();
        endcase
        if (show) begin
            r.cmd = {dm_hdr[5], dm_hdr[4]};
            r.flags = dm_hdr[1];
            r.seq = dm_hdr[6];
        end
        r.good = dm_good;
        r.fails = dm_fails;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
                 what, results_seen, got, want);
    endtask

    // monitor: output check, input prediction and register tracking
    always @(posedge clk) begin
        rx_taken = rst_n && rx_valid && rx_ready;
        if (rst_n) begin
            if (ev_valid && ev_ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected transaction", 32'(ev_user), 32'd0);
                end else begin
                    due_now = results_due.pop_front();
                    if (ev_user !== due_now.ev)
                        report_mismatch("event", 32'(ev_user), 32'(due_now.ev));
                    if (ev_data[7:0] !== due_now.data)
                        report_mismatch("data_byte", 32'(ev_data[7:0]), 32'(due_now.data));
                    if (ev_data[15:8] !== due_now.idx)
                        report_mismatch("payload_index", 32'(ev_data[15:8]),
                                        32'(due_now.idx));
                    if (ev_data[31:16] !== due_now.cmd)
                        report_mismatch("frame_cmd", 32'(ev_data[31:16]), 32'(due_now.cmd));
                    if (ev_data[39:32] !== due_now.flags)
                        report_mismatch("frame_flags", 32'(ev_data[39:32]),
                                        32'(due_now.flags));
                    if (ev_data[47:40] !== due_now.seq)
                        report_mismatch("frame_seq", 32'(ev_data[47:40]), 32'(due_now.seq));
                    if (ev_data[56:48] !== due_now.plen)
                        report_mismatch("payload_length", 32'(ev_data[56:48]),
                                        32'(due_now.plen));
                    if (ev_data[88:57] !== due_now.good)
                        report_mismatch("good_frames", ev_data[88:57], due_now.good);
                    if (ev_data[120:89] !== due_now.fails)
                        report_mismatch("crc_failures", ev_data[120:89], due_now.fails);
                    if (ev_data[127:121] !== 7'd0)
                        report_mismatch("padding", 32'(ev_data[127:121]), 32'd0);
                end
                results_seen++;
            end
            if (rx_taken) results_due.push_back(deframe_byte(rx_data));
            if (cfg_we) begin
                if (cfg_idx == fdcrc_pkg::REG_EXP_VERSION) dm_ver = cfg_wdata[7:0];
                else dm_max = cfg_wdata;
            end
        end
    end

    // byte driver
    always @(negedge clk) begin
        if (!rst_n) begin
            rx_valid <= 1'b0;
        end else if (!rx_valid || rx_taken) begin
            if (tx_gap > 0) begin
                rx_valid <= 1'b0;
                tx_gap--;
            end else if (rx_backlog.size() != 0) begin
                rx_valid <= 1'b1;
                rx_data <= rx_backlog.pop_front();
                tx_pick = $urandom_range(0, 99);
                if (!sender_gaps || tx_pick < 60) tx_gap = 0;
                else if (tx_pick < 94) tx_gap = $urandom_range(1, 3);
                else tx_gap = $urandom_range(8, 50);
            end else begin
                rx_valid <= 1'b0;
            end
        end
    end

    // result sink with random stalls and requested long hold-offs
    always @(negedge clk) begin
        if (hold_left > 0) begin
            ev_ready <= 1'b0;
            hold_left--;
        end else if (holds_asked != holds_served) begin
            ev_ready <= 1'b0;
            holds_served++;
            hold_left = LONG_HOLD;
        end else if (!sink_stalls) begin
            ev_ready <= 1'b1;
        end else begin
            sink_pick = $urandom_range(0, 99);
            if (sink_pick < 70) begin
                ev_ready <= 1'b1;
            end else if (sink_pick < 96) begin
                ev_ready <= 1'b0;
                hold_left = $urandom_range(0, 3);
            end else begin
                ev_ready <= 1'b0;
                hold_left = $urandom_range(10, 60);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        rx_backlog.push_back(b);
        bytes_made++;
    endtask

    // sync pair, header, payload (none above cap) and trailer; a cut in [0, size) truncates it
    task automatic queue_frame(input logic [7:0] ver, input logic [7:0] flags, input int len,
                               input logic [15:0] cmd, input logic [7:0] seq,
                               input bit bad_crc, input int cut);
        logic [7:0]  raw [$];
        logic [15:0] crc;
        int          n;
        raw.push_back(SYNC_FIRST);
        raw.push_back(SYNC_SECOND);
        raw.push_back(ver);
        raw.push_back(flags);
        raw.push_back(len[7:0]);
        raw.push_back(len[15:8]);
        raw.push_back(cmd[7:0]);
        raw.push_back(cmd[15:8]);
        raw.push_back(seq);
        if (len <= PAYLOAD_CAP) repeat (len) raw.push_back(8'($urandom));
        crc = CRC16_SEED;
        for (int i = 2; i < raw.size(); i++) crc = crc16_step(crc, raw[i]);
        if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        raw.push_back(crc[7:0]);
        raw.push_back(crc[15:8]);
        n = (cut >= 0 && cut < raw.size()) ? cut : raw.size();
        for (int i = 0; i < n; i++) push_byte(raw[i]);
    endtask

    task automatic queue_random_frame();
        int         pick;
        int         cap;
        int         len;
        logic [7:0] flags;
        cap = (gen_max > PAYLOAD_CAP) ? PAYLOAD_CAP : int'(gen_max);
        pick = $urandom_range(0, 99);
        flags = 8'($urandom);
        if ($urandom_range(0, 3) != 0) flags[0] = 1'b1;
        if ($urandom_range(0, 9) == 0) len = $urandom_range(0, cap);
        else len = $urandom_range(0, (cap < 12) ? cap : 12);
        // a doubled first sync byte ahead of some frames
        if (pick < 8) push_byte(SYNC_FIRST);
        if (pick < 72) begin
            queue_frame(gen_ver, flags, len, 16'($urandom), 8'($urandom),
                        $urandom_range(0, 6) == 0, -1);
        end else if (pick < 80) begin
            if ($urandom_range(0, 1) == 1)
                queue_frame(gen_ver ^ (8'h01 << $urandom_range(0, 7)), flags, len,
                            16'($urandom), 8'($urandom), 1'b0, -1);
            else if ($urandom_range(0, 1) == 1)
                queue_frame(gen_ver, flags, cap + 1, 16'($urandom), 8'($urandom), 1'b0, -1);
            else
                queue_frame(gen_ver, flags, $urandom_range(cap + 1, 65535), 16'($urandom),
                            8'($urandom), 1'b0, -1);
        end else if (pick < 90) begin
            repeat ($urandom_range(1, 8))
                push_byte(($urandom_range(0, 3) == 0) ? SYNC_FIRST : 8'($urandom));
        end else begin
            queue_frame(gen_ver, flags, len, 16'($urandom), 8'($urandom), 1'b0,
                        $urandom_range(1, len + 10));
        end
    endtask

    task automatic queue_random_run(input int n);
        int start;
        start = bytes_made;
        while (bytes_made - start < n) queue_random_frame();
    endtask

    task automatic write_config(input logic [7:0] ver, input logic [8:0] maxlen);
        logic junk;
        junk = 1'($urandom);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_idx = fdcrc_pkg::REG_EXP_VERSION;
        cfg_wdata = {junk, ver};
        @(negedge clk);
        cfg_idx = fdcrc_pkg::REG_MAX_LENGTH;
        cfg_wdata = maxlen;
        @(negedge clk);
        cfg_we = 1'b0;
        gen_ver = ver;
        gen_max = maxlen;
    endtask

    // waits until the backlog is sent and every outstanding result has come back
    task automatic drain();
        while (rx_backlog.size() != 0 || rx_valid || results_due.size() != 0) @(posedge clk);
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset settings, no idling
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(SYNC_FIRST);
        queue_frame(8'h02, 8'hFF, 0, 16'hFFFF, 8'hFF, 1'b0, -1);
        push_byte(SYNC_FIRST);
        push_byte(8'h00);
        queue_frame(8'h02, 8'h00, 1, 16'h0000, 8'h00, 1'b0, -1);
        queue_frame(8'h02, 8'h01, 2, 16'h1234, 8'h07, 1'b1, -1);
        queue_frame(8'h03, 8'h01, 0, 16'h00A5, 8'h5A, 1'b0, -1);
        queue_frame(8'h02, 8'h01, 257, 16'h8001, 8'h80, 1'b0, -1);
        queue_frame(8'h02, 8'h01, 65535, 16'h7FFE, 8'h01, 1'b0, -1);
        drain();

        // limit register above the payload cap, long sink hold-off
        write_config(8'h02, 9'h1FF);
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        holds_asked++;
        queue_frame(8'h02, 8'h01, 256, 16'hC3C3, 8'h3C, 1'b0, -1);
        queue_frame(8'h02, 8'h01, 257, 16'h0001, 8'h02, 1'b0, -1);
        queue_random_run(RUN_BYTES);
        drain();

        // lowest settings: only empty payloads pass
        write_config(8'h00, 9'h000);
        sink_stalls = 1'b0;
        queue_frame(8'h00, 8'h01, 1, 16'h4242, 8'h11, 1'b0, -1);
        queue_frame(8'h00, 8'h01, 0, 16'h2424, 8'h22, 1'b0, -1);
        queue_random_run(RUN_BYTES);
        drain();

        write_config(8'hFF, 9'($urandom_range(1, 40)));
        sender_gaps = 1'b0;
        sink_stalls = 1'b1;
        queue_random_run(RUN_BYTES);
        drain();

        write_config(8'($urandom), 9'($urandom_range(0, 300)));
        sender_gaps = 1'b1;
        holds_asked++;
        queue_random_run(RUN_BYTES);
        drain();

        repeat (4) @(posedge clk);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### files.f
+incdir+rtl
rtl/fdcrc_pkg.sv
rtl/frame_deframer_crc16_check.sv
sim/testbench.sv
